[hw/rtl/segment_circle_lookahead_point_unit_defines.svh]
// Assertion macros shared by the lookahead point unit.
// Needs a clk and an active-low rst_n in the scope where they are used.
`ifndef SEGMENT_CIRCLE_LOOKAHEAD_POINT_UNIT_DEFINES_SVH
`define SEGMENT_CIRCLE_LOOKAHEAD_POINT_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCPL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scpl assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SCPL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scpl assertion failed");

`endif

[hw/rtl/scpl_pkg.sv]
// Types and fixed widths of the lookahead point unit.
// Used by every module of the unit; depends on nothing.
package scpl_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int A_W     = 33;
    localparam int H_W     = 34;
    localparam int CR_W    = 35;
    localparam int CRM_W   = 33;
    localparam int R2_W    = 32;
    localparam int AR2_W   = A_W + R2_W;
    localparam int RAD_W   = 2 * CRM_W;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 4;
    localparam int N_W     = 36;
    localparam int P_W     = DIFF_W + N_W;
    localparam int NUM_W   = 52;
    localparam int DREM_W  = A_W + 1;

    localparam logic [0:0] REG_FORWARD  = 1'b0;
    localparam logic [0:0] REG_BACKWARD = 1'b1;

    typedef struct packed {
        logic               moving_forward;
        logic signed [15:0] tractor_y;
        logic signed [15:0] tractor_x;
        logic signed [15:0] trailer_y;
        logic signed [15:0] trailer_x;
        logic signed [15:0] seg_end_y;
        logic signed [15:0] seg_end_x;
        logic signed [15:0] seg_start_y;
        logic signed [15:0] seg_start_x;
    } query_t;

    typedef struct packed {
        logic                      found;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [H_W-1:0]     h;
        logic [A_W-1:0]            a;
    } root_side_t;

    typedef struct packed {
        logic                      found;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic                      negx;
        logic                      negy;
        logic [A_W-1:0]            a;
    } div_side_t;

endpackage

[hw/rtl/scpl_front.sv]
// Front stages: differences, products, squared radius and discriminant.
// Depends on scpl_pkg.
module scpl_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  scpl_pkg::query_t                  query,
    input  logic [15:0]                       forward_radius,
    input  logic [15:0]                       backward_radius,
    output logic                              out_valid,
    output logic [scpl_pkg::RAD_W-1:0]        disc,
    output scpl_pkg::root_side_t              side
);

    localparam int DW = scpl_pkg::DIFF_W;
    localparam int PW = scpl_pkg::PROD_W;
    localparam int CW = scpl_pkg::COORD_W;

    logic [4:0] valid_reg;

    // Stage 1
    logic signed [DW-1:0] dx_reg, dy_reg, fx_reg, fy_reg;
    logic signed [CW-1:0] sx1_reg, sy1_reg;
    logic [15:0]          r_reg;
    logic signed [CW-1:0] cx_next, cy_next;

    // Stage 2
    logic signed [PW-1:0] dxx_reg, dyy_reg, fdx_reg, fdy_reg, fxdy_reg, fydx_reg;
    logic [scpl_pkg::R2_W-1:0] rr_reg;
    logic signed [DW-1:0] dx2_reg, dy2_reg;
    logic signed [CW-1:0] sx2_reg, sy2_reg;

    // Stage 3
    logic [scpl_pkg::A_W-1:0]          a3_reg;
    logic signed [scpl_pkg::H_W-1:0]   h3_reg;
    logic [scpl_pkg::CRM_W-1:0]        crm_reg;
    logic [scpl_pkg::R2_W-1:0]         rr3_reg;
    logic signed [DW-1:0]              dx3_reg, dy3_reg;
    logic signed [CW-1:0]              sx3_reg, sy3_reg;
    logic signed [PW-1:0]              a_sum;
    logic signed [scpl_pkg::CR_W-1:0]  cr_next;
    logic signed [scpl_pkg::CR_W-1:0]  cr_abs;

    // Stage 4
    logic [scpl_pkg::AR2_W-1:0]        ar2_reg;
    logic [scpl_pkg::RAD_W-1:0]        cr2_reg;
    logic [scpl_pkg::A_W-1:0]          a4_reg;
    logic signed [scpl_pkg::H_W-1:0]   h4_reg;
    logic signed [DW-1:0]              dx4_reg, dy4_reg;
    logic signed [CW-1:0]              sx4_reg, sy4_reg;

    // Stage 5
    logic [scpl_pkg::RAD_W-1:0]        disc_reg;
    scpl_pkg::root_side_t              side_reg;
    logic [scpl_pkg::RAD_W-1:0]        ar2_ext;
    logic                              found_next;

    assign cx_next = query.moving_forward ? query.tractor_x : query.trailer_x;
    assign cy_next = query.moving_forward ? query.tractor_y : query.trailer_y;

    assign a_sum   = dxx_reg + dyy_reg;
    assign cr_next = scpl_pkg::CR_W'(fxdy_reg) - scpl_pkg::CR_W'(fydx_reg);
    assign cr_abs  = cr_next[scpl_pkg::CR_W-1] ? -cr_next : cr_next;

    assign ar2_ext    = {1'b0, ar2_reg};
    assign found_next = (a4_reg != '0) && (ar2_ext >= cr2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= DW'(query.seg_end_x) - DW'(query.seg_start_x);
            dy_reg  <= DW'(query.seg_end_y) - DW'(query.seg_start_y);
            fx_reg  <= DW'(query.seg_start_x) - DW'(cx_next);
            fy_reg  <= DW'(query.seg_start_y) - DW'(cy_next);
            r_reg   <= query.moving_forward ? forward_radius : backward_radius;
            sx1_reg <= query.seg_start_x;
            sy1_reg <= query.seg_start_y;

            dxx_reg  <= dx_reg * dx_reg;
            dyy_reg  <= dy_reg * dy_reg;
            fdx_reg  <= fx_reg * dx_reg;
            fdy_reg  <= fy_reg * dy_reg;
            fxdy_reg <= fx_reg * dy_reg;
            fydx_reg <= fy_reg * dx_reg;
            rr_reg   <= r_reg * r_reg;
            dx2_reg  <= dx_reg;
            dy2_reg  <= dy_reg;
            sx2_reg  <= sx1_reg;
            sy2_reg  <= sy1_reg;

            a3_reg  <= a_sum[scpl_pkg::A_W-1:0];
            h3_reg  <= fdx_reg + fdy_reg;
            crm_reg <= cr_abs[scpl_pkg::CRM_W-1:0];
            rr3_reg <= rr_reg;
            dx3_reg <= dx2_reg;
            dy3_reg <= dy2_reg;
            sx3_reg <= sx2_reg;
            sy3_reg <= sy2_reg;

            ar2_reg <= a3_reg * rr3_reg;
            cr2_reg <= crm_reg * crm_reg;
            a4_reg  <= a3_reg;
            h4_reg  <= h3_reg;
            dx4_reg <= dx3_reg;
            dy4_reg <= dy3_reg;
            sx4_reg <= sx3_reg;
            sy4_reg <= sy3_reg;

            // A miss feeds a zero radicand so the later stages stay quiet.
            disc_reg       <= found_next ? ar2_ext - cr2_reg : '0;
            side_reg.found <= found_next;
            side_reg.sx    <= sx4_reg;
            side_reg.sy    <= sy4_reg;
            side_reg.dx    <= dx4_reg;
            side_reg.dy    <= dy4_reg;
            side_reg.h     <= h4_reg;
            side_reg.a     <= a4_reg;
        end
    end

    assign out_valid = valid_reg[4];
    assign disc      = disc_reg;
    assign side      = side_reg;

endmodule

[hw/rtl/scpl_sqrt.sv]
// Pipelined floor square root, one root bit per register stage.
// Depends on scpl_pkg.
module scpl_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [scpl_pkg::RAD_W-1:0]    rad,
    input  scpl_pkg::root_side_t          in_side,
    output logic                          out_valid,
    output logic [scpl_pkg::ROOT_W-1:0]   root,
    output scpl_pkg::root_side_t          out_side
);

    localparam int NS  = scpl_pkg::ROOT_W;
    localparam int RW  = scpl_pkg::RAD_W;
    localparam int RMW = scpl_pkg::REM_W;
    localparam int QW  = scpl_pkg::ROOT_W;

    logic                 valid_reg [1:NS];
    logic [RW-1:0]        rad_reg   [1:NS];
    logic [RMW-1:0]       rem_reg   [1:NS];
    logic [QW-1:0]        root_reg  [1:NS];
    scpl_pkg::root_side_t side_reg  [1:NS];

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        logic                 v_in;
        logic [RW-1:0]        rad_in;
        logic [RMW-1:0]       rem_in;
        logic [QW-1:0]        root_in;
        scpl_pkg::root_side_t side_in;
        logic [RMW-1:0]       rem_shift;
        logic [RMW-1:0]       trial;
        logic                 take;

        if (i == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = valid_reg[i];
            assign rad_in  = rad_reg[i];
            assign rem_in  = rem_reg[i];
            assign root_in = root_reg[i];
            assign side_in = side_reg[i];
        end

        // Bring down the next two radicand bits and try (4*root + 1).
        assign rem_shift = {rem_in[RMW-3:0], rad_in[RW-1 -: 2]};
        assign trial     = {{(RMW-QW-2){1'b0}}, root_in, 2'b01};
        assign take      = rem_shift >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i+1] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i+1]  <= {rad_in[RW-3:0], 2'b00};
                rem_reg[i+1]  <= take ? rem_shift - trial : rem_shift;
                root_reg[i+1] <= {root_in[QW-2:0], take};
                side_reg[i+1] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[NS];
    assign root      = root_reg[NS];
    assign out_side  = side_reg[NS];

endmodule

[hw/rtl/scpl_scale.sv]
// Scaling stages: n = root - h, products d*n, magnitudes with half divisor added.
// Depends on scpl_pkg.
module scpl_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [scpl_pkg::ROOT_W-1:0]   root,
    input  scpl_pkg::root_side_t          in_side,
    output logic                          out_valid,
    output logic [scpl_pkg::NUM_W-1:0]    num_x,
    output logic [scpl_pkg::NUM_W-1:0]    num_y,
    output scpl_pkg::div_side_t           out_side
);

    localparam int NW = scpl_pkg::N_W;
    localparam int PW = scpl_pkg::P_W;
    localparam int MW = scpl_pkg::NUM_W;
    localparam int AW = scpl_pkg::A_W;

    logic [2:0]            valid_reg;
    logic signed [NW-1:0]  n_reg;
    scpl_pkg::root_side_t  s1_reg, s2_reg;
    logic signed [PW-1:0]  px_reg, py_reg;
    logic [MW-1:0]         mx_reg, my_reg;
    scpl_pkg::div_side_t   s3_reg;
    logic signed [PW-1:0]  px_abs, py_abs;
    logic [MW-1:0]         half_a;

    assign px_abs = px_reg[PW-1] ? -px_reg : px_reg;
    assign py_abs = py_reg[PW-1] ? -py_reg : py_reg;
    assign half_a = MW'(s2_reg.a[AW-1:1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg  <= $signed(NW'(root)) - NW'(in_side.h);
            s1_reg <= in_side;

            px_reg <= s1_reg.dx * n_reg;
            py_reg <= s1_reg.dy * n_reg;
            s2_reg <= s1_reg;

            // Adding half the divisor before truncating rounds ties away from zero.
            mx_reg       <= px_abs[MW-1:0] + half_a;
            my_reg       <= py_abs[MW-1:0] + half_a;
            s3_reg.found <= s2_reg.found;
            s3_reg.sx    <= s2_reg.sx;
            s3_reg.sy    <= s2_reg.sy;
            s3_reg.negx  <= px_reg[PW-1];
            s3_reg.negy  <= py_reg[PW-1];
            s3_reg.a     <= s2_reg.a;
        end
    end

    assign out_valid = valid_reg[2];
    assign num_x     = mx_reg;
    assign num_y     = my_reg;
    assign out_side  = s3_reg;

endmodule

[hw/rtl/scpl_div.sv]
// Pipelined restoring divider for both coordinates, one quotient bit per stage.
// Depends on scpl_pkg.
module scpl_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [scpl_pkg::NUM_W-1:0]    num_x,
    input  logic [scpl_pkg::NUM_W-1:0]    num_y,
    input  scpl_pkg::div_side_t           in_side,
    output logic                          out_valid,
    output logic [scpl_pkg::NUM_W-1:0]    quo_x,
    output logic [scpl_pkg::NUM_W-1:0]    quo_y,
    output scpl_pkg::div_side_t           out_side
);

    localparam int NS = scpl_pkg::NUM_W;
    localparam int MW = scpl_pkg::NUM_W;
    localparam int RW = scpl_pkg::DREM_W;

    logic                valid_reg [1:NS];
    logic [MW-1:0]       qx_reg    [1:NS];
    logic [MW-1:0]       qy_reg    [1:NS];
    logic [RW-1:0]       rx_reg    [1:NS];
    logic [RW-1:0]       ry_reg    [1:NS];
    scpl_pkg::div_side_t side_reg  [1:NS];

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        logic                v_in;
        logic [MW-1:0]       qx_in, qy_in;
        logic [RW-1:0]       rx_in, ry_in;
        scpl_pkg::div_side_t side_in;
        logic [RW-1:0]       rx_shift, ry_shift, den;
        logic                take_x, take_y;

        if (i == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign qx_in   = num_x;
            assign qy_in   = num_y;
            assign rx_in   = '0;
            assign ry_in   = '0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = valid_reg[i];
            assign qx_in   = qx_reg[i];
            assign qy_in   = qy_reg[i];
            assign rx_in   = rx_reg[i];
            assign ry_in   = ry_reg[i];
            assign side_in = side_reg[i];
        end

        // The dividend shifts out at the top while quotient bits fill the bottom.
        assign den      = {1'b0, side_in.a};
        assign rx_shift = {rx_in[RW-2:0], qx_in[MW-1]};
        assign ry_shift = {ry_in[RW-2:0], qy_in[MW-1]};
        assign take_x   = rx_shift >= den;
        assign take_y   = ry_shift >= den;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i+1] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[i+1]   <= take_x ? rx_shift - den : rx_shift;
                ry_reg[i+1]   <= take_y ? ry_shift - den : ry_shift;
                qx_reg[i+1]   <= {qx_in[MW-2:0], take_x};
                qy_reg[i+1]   <= {qy_in[MW-2:0], take_y};
                side_reg[i+1] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[NS];
    assign quo_x     = qx_reg[NS];
    assign quo_y     = qy_reg[NS];
    assign out_side  = side_reg[NS];

endmodule

[hw/rtl/segment_circle_lookahead_point_unit.sv]
// Top level of the lookahead point unit: register port, pipeline and output stage.
// Depends on scpl_pkg, scpl_front, scpl_sqrt, scpl_scale, scpl_div and the defines header.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------
//  s_axis    | tvalid / tready         | tdata: 8 coordinates, tuser: moving_forward
//  m_axis    | tvalid / tready         | tdata: point_x, point_y, tuser: found
//  apb       | psel, penable, pready   | paddr, pwdata, prdata (radius registers)
//
// One request enters per cycle while the pipeline is not held; each passes through
// 5 front stages, 33 square root stages, 3 scaling stages, 52 divider stages and
// the output stage, which also saturates. The root and the divider set the depth.
// The whole pipeline holds while a finished result waits and m_axis_tready is low.
// Reset is asynchronous; it clears valid bits and sets both radii to 1.0.
`include "segment_circle_lookahead_point_unit_defines.svh"

module segment_circle_lookahead_point_unit #(
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    // trailer_x, trailer_y, tractor_x, tractor_y (16 bits each)
    input  logic [127:0] s_axis_tdata,
    input  logic         s_axis_tuser,   // moving_forward
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // point_x, point_y
    output logic         m_axis_tuser,   // found
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [15:0] RADIUS_RESET = 16'(1 << COORD_FRAC_BITS);
    localparam int MW = scpl_pkg::NUM_W;

    logic [15:0]  fwd_radius_reg, bwd_radius_reg;
    logic         adv;
    logic         cfg_write;
    scpl_pkg::query_t query;

    logic                          fr_valid;
    logic [scpl_pkg::RAD_W-1:0]    fr_disc;
    scpl_pkg::root_side_t          fr_side;
    logic                          sq_valid;
    logic [scpl_pkg::ROOT_W-1:0]   sq_root;
    scpl_pkg::root_side_t          sq_side;
    logic                          sc_valid;
    logic [MW-1:0]                 sc_num_x, sc_num_y;
    scpl_pkg::div_side_t           sc_side;
    logic                          dv_valid;
    logic [MW-1:0]                 dv_quo_x, dv_quo_y;
    scpl_pkg::div_side_t           dv_side;

    logic signed [MW+1:0]          sum_x, sum_y;
    logic [15:0]                   px_next, py_next;
    logic                          out_valid_reg;
    logic [31:0]                   out_data_reg;
    logic                          out_found_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_radius_reg <= RADIUS_RESET;
            bwd_radius_reg <= RADIUS_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                scpl_pkg::REG_FORWARD:  fwd_radius_reg <= pwdata[15:0];
                scpl_pkg::REG_BACKWARD: bwd_radius_reg <= pwdata[15:0];
                default:                fwd_radius_reg <= fwd_radius_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            scpl_pkg::REG_FORWARD:  prdata = {16'd0, fwd_radius_reg};
            scpl_pkg::REG_BACKWARD: prdata = {16'd0, bwd_radius_reg};
            default:                prdata = '0;
        endcase
    end

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign query         = {s_axis_tuser, s_axis_tdata};

    scpl_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (adv),
        .in_valid        (s_axis_tvalid),
        .query           (query),
        .forward_radius  (fwd_radius_reg),
        .backward_radius (bwd_radius_reg),
        .out_valid       (fr_valid),
        .disc            (fr_disc),
        .side            (fr_side)
    );

    scpl_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (fr_valid),
        .rad       (fr_disc),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    scpl_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sq_valid),
        .root      (sq_root),
        .in_side   (sq_side),
        .out_valid (sc_valid),
        .num_x     (sc_num_x),
        .num_y     (sc_num_y),
        .out_side  (sc_side)
    );

    scpl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sc_valid),
        .num_x     (sc_num_x),
        .num_y     (sc_num_y),
        .in_side   (sc_side),
        .out_valid (dv_valid),
        .quo_x     (dv_quo_x),
        .quo_y     (dv_quo_y),
        .out_side  (dv_side)
    );

    // Restore the sign of the rounded quotient, add the start point and saturate.
    assign sum_x = (dv_side.negx ? -$signed({2'b00, dv_quo_x}) : $signed({2'b00, dv_quo_x}))
                   + (MW+2)'(dv_side.sx);
    assign sum_y = (dv_side.negy ? -$signed({2'b00, dv_quo_y}) : $signed({2'b00, dv_quo_y}))
                   + (MW+2)'(dv_side.sy);

    always_comb
    begin
        if (sum_x > 32767)
            px_next = 16'h7FFF;
        else if (sum_x < -32768)
            px_next = 16'h8000;
        else
            px_next = sum_x[15:0];
        if (sum_y > 32767)
            py_next = 16'h7FFF;
        else if (sum_y < -32768)
            py_next = 16'h8000;
        else
            py_next = sum_y[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_found_reg <= dv_side.found;
            out_data_reg  <= dv_side.found ? {py_next, px_next} : 32'd0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_found_reg;

    `SCPL_ASSERT_SAME(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 32'd0)
    `SCPL_ASSERT_NEXT(a_fwd_write,
                      cfg_write && (paddr[2] == scpl_pkg::REG_FORWARD),
                      fwd_radius_reg == $past(pwdata[15:0]))
    `SCPL_ASSERT_NEXT(a_stall_hold, !adv, $stable(sq_valid) && $stable(dv_valid))

endmodule

[test/tb_top.sv]
// Self-checking bench for the segment/circle lookahead point unit.
// Depends on scpl_pkg and segment_circle_lookahead_point_unit; predicts each point in integers.
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic               found;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
    } lookahead_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    localparam int LATENCY = 94;
    localparam logic [2:0] ADDR_FORWARD  = 3'd0;
    localparam logic [2:0] ADDR_BACKWARD = 3'd4;

    logic [15:0] fwd_radius;
    logic [15:0] bwd_radius;
    lookahead_t  expected_points[$];
    int          error_count;
    longint      cycle_count;
    int          hold_cycles;
    bit          random_stall;

    segment_circle_lookahead_point_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 3000000)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Exact floor square root of a value below 2^72, bit by bit.
    function automatic logic [35:0] isqrt(input logic [71:0] v);
        logic [35:0] res;
        logic [35:0] cand;
        res = '0;
        for (int b = 35; b >= 0; b--)
        begin
            cand = res | (36'd1 << b);
            if ({36'd0, cand} * {36'd0, cand} <= v)
                res = cand;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [71:0] v);
        if (v > 72'sd32767)
            return 16'sh7fff;
        if (v < -72'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Rounds num/den to nearest, ties away from zero.
    function automatic logic signed [71:0] div_round(input logic signed [71:0] num,
                                                     input logic signed [71:0] den);
        logic signed [71:0] m;
        logic signed [71:0] q;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic lookahead_t lookahead_point(input scpl_pkg::query_t q);
        logic signed [71:0] sx, sy, cx, cy, dx, dy, fx, fy, a, h, cr, r, ar2, cr2, n;
        lookahead_t res;
        sx = 72'(q.seg_start_x);
        sy = 72'(q.seg_start_y);
        cx = q.moving_forward ? 72'(q.tractor_x) : 72'(q.trailer_x);
        cy = q.moving_forward ? 72'(q.tractor_y) : 72'(q.trailer_y);
        r  = q.moving_forward ? {56'd0, fwd_radius} : {56'd0, bwd_radius};
        dx = 72'(q.seg_end_x) - sx;
        dy = 72'(q.seg_end_y) - sy;
        fx = sx - cx;
        fy = sy - cy;
        a  = dx * dx + dy * dy;
        h  = fx * dx + fy * dy;
        cr = fx * dy - fy * dx;
        res = '0;
        if (a == 0)
            return res;
        ar2 = a * r * r;
        cr2 = cr * cr;
        if (ar2 < cr2)
            return res;
        n = $signed({36'd0, isqrt(ar2 - cr2)}) - h;
        res.found   = 1'b1;
        res.point_x = clamp16(sx + div_round(dx * n, a));
        res.point_y = clamp16(sy + div_round(dy * n, a));
        return res;
    endfunction

    task automatic write_radius(input logic [2:0] addr, input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_FORWARD)
            fwd_radius = value;
        else
            bwd_radius = value;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // The request stays offered after acceptance so the next one can follow
    // back to back; gaps and drains take the valid down.
    task automatic send_query(input scpl_pkg::query_t q, input bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 2) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= q[127:0];
        s_axis_tuser  <= q.moving_forward;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_points.push_back(lookahead_point(q));
    endtask

    function automatic logic signed [15:0] pick_coord(input logic signed [15:0] base,
                                                      input int spread);
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom());
            default: return base + $signed(16'($urandom_range(0, 2 * spread) - spread));
        endcase
    endfunction

    function automatic scpl_pkg::query_t random_query(input int spread);
        scpl_pkg::query_t q;
        logic signed [15:0] cx, cy;
        cx = 16'($urandom());
        cy = 16'($urandom());
        q.moving_forward = 1'($urandom_range(0, 1));
        q.seg_start_x = pick_coord(cx, spread);
        q.seg_start_y = pick_coord(cy, spread);
        q.seg_end_x   = ($urandom_range(0, 30) == 0) ? q.seg_start_x : pick_coord(cx, spread);
        q.seg_end_y   = ($urandom_range(0, 30) == 0) ? q.seg_start_y : pick_coord(cy, spread);
        q.tractor_x   = q.moving_forward ? cx : 16'($urandom());
        q.tractor_y   = q.moving_forward ? cy : 16'($urandom());
        q.trailer_x   = q.moving_forward ? 16'($urandom()) : cx;
        q.trailer_y   = q.moving_forward ? 16'($urandom()) : cy;
        return q;
    endfunction

    function automatic scpl_pkg::query_t make_query(input int sx, sy, ex, ey, cx, cy,
                                                    input bit fwd);
        scpl_pkg::query_t q;
        q.seg_start_x = 16'(sx);
        q.seg_start_y = 16'(sy);
        q.seg_end_x   = 16'(ex);
        q.seg_end_y   = 16'(ey);
        q.tractor_x   = 16'(fwd ? cx : -cx);
        q.tractor_y   = 16'(fwd ? cy : -cy);
        q.trailer_x   = 16'(fwd ? -cx : cx);
        q.trailer_y   = 16'(fwd ? -cy : cy);
        q.moving_forward = fwd;
        return q;
    endfunction

    task automatic test_directed();
        // Hits, tangent, miss, zero length, saturation and field extremes.
        send_query(make_query(-512, 0, 512, 0, 0, 0, 1'b1), 0);
        send_query(make_query(-512, 0, 512, 0, 0, 0, 1'b0), 0);
        send_query(make_query(-512, 256, 512, 256, 0, 0, 1'b1), 0);
        send_query(make_query(-512, 600, 512, 600, 0, 0, 1'b0), 0);
        send_query(make_query(100, 100, 100, 100, 0, 0, 1'b1), 0);
        send_query(make_query(100, 100, 100, 100, 0, 0, 1'b0), 0);
        send_query(make_query(32767, 32767, -32768, -32768, 0, 0, 1'b1), 0);
        send_query(make_query(-32768, 32767, 32767, -32768, 32767, 32767, 1'b0), 0);
        send_query(make_query(32760, 0, 32767, 0, 32767, 0, 1'b1), 0);
        send_query(make_query(0, -32768, 0, -32760, 0, -32768, 1'b0), 0);
        send_query(make_query(0, 0, 1, 0, 0, 0, 1'b1), 0);
        send_query(make_query(0, 0, 0, -1, 5, 5, 1'b0), 0);
        send_query('1, 0);
        send_query('0, 0);
        send_query({1'b1, {8{16'h5555}}}, 0);
        send_query({1'b0, {8{16'haaaa}}}, 0);
        drain_results();
        write_radius(ADDR_FORWARD, 16'hffff);
        write_radius(ADDR_BACKWARD, 16'h0000);
        send_query(make_query(-100, 0, 100, 0, 0, 0, 1'b1), 0);
        send_query(make_query(-32768, -32768, 32767, 32767, 0, 0, 1'b1), 0);
        send_query(make_query(-100, 0, 100, 0, 0, 0, 1'b0), 0);
        send_query(make_query(-100, 0, 100, 0, 0, 1, 1'b0), 0);
        drain_results();
    endtask

    task automatic test_random(input int count, input int spread);
        for (int i = 0; i < count; i++)
            send_query(random_query(spread), 1);
        drain_results();
    endtask

    task automatic test_backpressure();
        // Receiver stops long enough for the pipeline to fill and stall the input.
        hold_cycles = 300;
        for (int i = 0; i < 150; i++)
            send_query(random_query(2000), 0);
        drain_results();
    endtask

    task automatic test_radius_sweep();
        logic [15:0] radii[4];
        radii = '{16'h0000, 16'h0001, 16'h8000, 16'hffff};
        foreach (radii[i])
        begin
            write_radius(ADDR_FORWARD, radii[i]);
            write_radius(ADDR_BACKWARD, radii[3 - i]);
            test_random(200, 4000);
        end
        write_radius(ADDR_FORWARD, 16'($urandom_range(64, 2048)));
        write_radius(ADDR_BACKWARD, 16'($urandom_range(64, 2048)));
        test_random(400, 1500);
    endtask

    // Result side: random stalls that sometimes become hold-offs, plus one long hold-off when requested.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end
            else if (random_stall && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                if ($urandom_range(0, 9) == 0)
                    hold_cycles = $urandom_range(5, 30);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        lookahead_t exp_pt;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("unexpected result: found=%0b data=%h", m_axis_tuser, m_axis_tdata);
                error_count++;
            end
            else
            begin
                exp_pt = expected_points.pop_front();
                if (m_axis_tuser !== exp_pt.found)
                begin
                    $error("found: expected %0b, got %0b", exp_pt.found, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[15:0] !== exp_pt.point_x)
                begin
                    $error("point_x: expected %0d, got %0d", exp_pt.point_x,
                           $signed(m_axis_tdata[15:0]));
                    error_count++;
                end
                if (m_axis_tdata[31:16] !== exp_pt.point_y)
                begin
                    $error("point_y: expected %0d, got %0d", exp_pt.point_y,
                           $signed(m_axis_tdata[31:16]));
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        fwd_radius    = 16'd256;
        bwd_radius    = 16'd256;
        error_count   = 0;
        hold_cycles   = 0;
        random_stall  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        random_stall = 1'b1;
        test_random(300, 1000);
        test_backpressure();
        test_radius_sweep();
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
